@@ hw/rtl/size_class_free_map_unit_assert.svh @@
// Assertion macros for the size-class free map unit.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef SIZE_CLASS_FREE_MAP_UNIT_ASSERT_SVH
`define SIZE_CLASS_FREE_MAP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SCFM_ASSERT(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("scfm assertion failed");
`define SCFM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scfm assertion failed");
`else
`define SCFM_ASSERT(name, cond)
`define SCFM_ASSERT_NEXT(name, ante, cons)
`endif
`endif

@@ hw/rtl/scfm_pkg.sv @@
`timescale 1ns / 1ps
package scfm_pkg;

  localparam int unsigned CLASS_COUNT     = 48;
  localparam int unsigned CLASS_W         = $clog2(CLASS_COUNT);
  localparam int unsigned SIZE_W          = 32;
  localparam int unsigned SMALL_CLASSES   = 3;
  localparam int unsigned STEP_SIZE       = 32;
  localparam int unsigned MID_TOP         = 1024;
  localparam int unsigned MID_LAST_CLASS  = SMALL_CLASSES + MID_TOP / STEP_SIZE - 1;
  localparam int unsigned CATCH_ALL_CLASS = 43 + 3;
  localparam int unsigned TOP_SIZE        = 2 * 1024 * 1024;

  typedef logic [CLASS_W-1:0]     class_t;
  typedef logic [CLASS_COUNT-1:0] class_map_t;

  typedef enum logic [1:0] {
    CMD_FIND       = 2'd0,
    CMD_INSERT     = 2'd1,
    CMD_MARK_EMPTY = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_e;

endpackage

@@ hw/rtl/size_class_free_map_unit.sv @@
`timescale 1ns / 1ps
// A word accepted at an edge has its result loaded into the output register at that edge.
// Throughput: one word per cycle while out_ready_i keeps the output free; the search is combinational.
// A following word sees the map update of the word before it.
// Reset (rst_ni low, asynchronous): class map cleared, output register empty.
`include "size_class_free_map_unit_assert.svh"
module size_class_free_map_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       cmd_i,
  input  logic [scfm_pkg::SIZE_W-1:0]      request_size_i,
  input  logic [5:0]                       class_index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [5:0]                       ceiling_class_o,
  output logic [5:0]                       insert_class_o,
  output logic                             hit_o,
  output logic [5:0]                       hit_class_o,
  output logic                             fallback_valid_o,
  output logic [5:0]                       fallback_class_o
);

  logic                  in_fire;
  scfm_pkg::cmd_e        cmd;
  logic [11:0]           kb;
  logic [3:0]            fl;
  logic                  round_up;
  scfm_pkg::class_t      base_cls;
  scfm_pkg::class_t      ceil_cls;
  scfm_pkg::class_map_t  masked;
  scfm_pkg::class_map_t  lowest;
  scfm_pkg::class_t      first_cls;

  scfm_pkg::class_map_t  map_d, map_q;
  logic                  out_valid_d, out_valid_q;
  scfm_pkg::class_t      ceiling_d, ceiling_q;
  scfm_pkg::class_t      insert_d, insert_q;
  logic                  hit_d, hit_q;
  scfm_pkg::class_t      hit_cls_d, hit_cls_q;
  logic                  fb_valid_d, fb_valid_q;
  scfm_pkg::class_t      fb_cls_d, fb_cls_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign cmd        = scfm_pkg::cmd_e'(cmd_i);
  assign kb         = request_size_i[21:10];

  always_comb begin
    fl = '0;
    for (int i = 0; i < 12; i++) begin
      if (kb[i]) begin
        fl = 4'(i);
      end
    end
  end

  always_comb begin
    priority if (request_size_i < 32'd8) begin
      base_cls = '0;
      round_up = 1'b0;
    end else if (request_size_i < 32'(scfm_pkg::STEP_SIZE)) begin
      base_cls = scfm_pkg::CLASS_W'(request_size_i[4:3]) - scfm_pkg::CLASS_W'(1);
      round_up = |request_size_i[2:0];
    end else if (request_size_i <= 32'(scfm_pkg::MID_TOP)) begin
      base_cls = scfm_pkg::CLASS_W'(request_size_i[10:5])
               + scfm_pkg::CLASS_W'(scfm_pkg::SMALL_CLASSES - 1);
      round_up = |request_size_i[4:0];
    end else if (request_size_i > 32'(scfm_pkg::TOP_SIZE)) begin
      base_cls = scfm_pkg::CLASS_W'(scfm_pkg::CATCH_ALL_CLASS);
      round_up = 1'b0;
    end else begin
      base_cls = scfm_pkg::CLASS_W'(scfm_pkg::MID_LAST_CLASS) + scfm_pkg::CLASS_W'(fl);
      round_up = request_size_i != (32'(scfm_pkg::MID_TOP) << fl);
    end
  end

  assign ceil_cls = base_cls + scfm_pkg::CLASS_W'(round_up);
  assign masked   = map_q & ({scfm_pkg::CLASS_COUNT{1'b1}} << ceil_cls);
  assign lowest   = masked & (~masked + scfm_pkg::CLASS_COUNT'(1));

  always_comb begin
    first_cls = '0;
    for (int i = 0; i < scfm_pkg::CLASS_COUNT; i++) begin
      if (lowest[i]) begin
        first_cls = first_cls | scfm_pkg::CLASS_W'(i);
      end
    end
  end

  always_comb begin
    map_d      = map_q;
    ceiling_d  = '0;
    insert_d   = '0;
    hit_d      = 1'b0;
    hit_cls_d  = '0;
    fb_valid_d = 1'b0;
    fb_cls_d   = '0;
    unique case (cmd)
      scfm_pkg::CMD_FIND: begin
        ceiling_d  = ceil_cls;
        hit_d      = |masked;
        hit_cls_d  = first_cls;
        fb_valid_d = ceil_cls != '0;
        fb_cls_d   = (ceil_cls != '0) ? ceil_cls - scfm_pkg::CLASS_W'(1) : '0;
      end
      scfm_pkg::CMD_INSERT: begin
        ceiling_d       = ceil_cls;
        insert_d        = base_cls;
        map_d[base_cls] = in_fire ? 1'b1 : map_q[base_cls];
      end
      scfm_pkg::CMD_MARK_EMPTY: begin
        if (in_fire && (32'(class_index_i) < 32'(scfm_pkg::CLASS_COUNT))) begin
          map_d[class_index_i] = 1'b0;
        end
      end
      scfm_pkg::CMD_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      map_q       <= map_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ceiling_q  <= ceiling_d;
      insert_q   <= insert_d;
      hit_q      <= hit_d;
      hit_cls_q  <= hit_cls_d;
      fb_valid_q <= fb_valid_d;
      fb_cls_q   <= fb_cls_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ceiling_class_o  = ceiling_q;
  assign insert_class_o   = insert_q;
  assign hit_o            = hit_q;
  assign hit_class_o      = hit_cls_q;
  assign fallback_valid_o = fb_valid_q;
  assign fallback_class_o = fb_cls_q;

  `SCFM_ASSERT_NEXT(a_insert_sets_bit, in_fire && (cmd == scfm_pkg::CMD_INSERT), map_q[$past(base_cls)])
  `SCFM_ASSERT(a_hit_at_or_above, !(out_valid_q && hit_q) || (hit_cls_q >= ceiling_q))
  `SCFM_ASSERT(a_miss_class_zero, !(out_valid_q && !hit_q) || (hit_cls_q == '0))
  `SCFM_ASSERT(a_fallback_below, !(out_valid_q && fb_valid_q) || (fb_cls_q + scfm_pkg::CLASS_W'(1) == ceiling_q))
  `SCFM_ASSERT(a_spare_never_set, map_q[scfm_pkg::CLASS_COUNT-1:scfm_pkg::CATCH_ALL_CLASS+1] == '0)

endmodule

@@ sim/tb_size_class_free_map_unit.sv @@
`timescale 1ns / 1ps
module tb_size_class_free_map_unit;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 60;

  typedef struct packed {
    logic [5:0] ceiling;
    logic [5:0] filed;
    logic       hit;
    logic [5:0] hit_cls;
    logic       fb_valid;
    logic [5:0] fb_cls;
  } map_result_t;

  class class_map_checker;
    map_result_t                      pending_results[$];
    logic [scfm_pkg::CLASS_COUNT-1:0] nonempty_bits;
    int                               mismatches;

    function new();
      nonempty_bits = '0;
      mismatches = 0;
    endfunction

    function int unsigned class_bytes(int unsigned c);
      if (c < scfm_pkg::SMALL_CLASSES) return 8 * (c + 1);
      if (c <= scfm_pkg::MID_LAST_CLASS) return scfm_pkg::STEP_SIZE * (c - 2);
      if (c < scfm_pkg::CATCH_ALL_CLASS)
        return scfm_pkg::MID_TOP << (c - scfm_pkg::MID_LAST_CLASS);
      return 32'hFFFF_FFFF;
    endfunction

    function int unsigned log2_floor(int unsigned v);
      int unsigned r;
      r = 0;
      while (v > 1) begin
        v = v >> 1;
        r++;
      end
      return r;
    endfunction

    function int unsigned ceiling_class(logic [31:0] sz);
      int unsigned c;
      if (sz < 8) return 0;
      if (sz < scfm_pkg::STEP_SIZE) c = sz / 8 - 1;
      else if (sz <= scfm_pkg::MID_TOP) c = (sz >> 5) - 1 + scfm_pkg::SMALL_CLASSES;
      else if (sz > scfm_pkg::TOP_SIZE) return scfm_pkg::CATCH_ALL_CLASS;
      else c = scfm_pkg::MID_LAST_CLASS + log2_floor(sz >> 10);
      if (class_bytes(c) < sz) c++;
      return c;
    endfunction

    function int unsigned floor_class(logic [31:0] sz);
      int unsigned c;
      c = ceiling_class(sz);
      if (c != 0 && c < scfm_pkg::CATCH_ALL_CLASS && class_bytes(c) != sz) c--;
      return c;
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    function void note_word(scfm_pkg::cmd_e c, logic [31:0] sz, logic [5:0] idx);
      map_result_t r;
      int unsigned ceil_c;
      int unsigned flr_c;
      r = '0;
      case (c)
        scfm_pkg::CMD_FIND: begin
          ceil_c = ceiling_class(sz);
          r.ceiling = 6'(ceil_c);
          for (int unsigned i = ceil_c; i < scfm_pkg::CLASS_COUNT; i++) begin
            if (nonempty_bits[i]) begin
              r.hit = 1'b1;
              r.hit_cls = 6'(i);
              break;
            end
          end
          if (ceil_c != 0) begin
            r.fb_valid = 1'b1;
            r.fb_cls = 6'(ceil_c - 1);
          end
        end
        scfm_pkg::CMD_INSERT: begin
          flr_c = floor_class(sz);
          r.ceiling = 6'(ceiling_class(sz));
          r.filed = 6'(flr_c);
          if (flr_c < scfm_pkg::CLASS_COUNT) nonempty_bits[flr_c] = 1'b1;
        end
        scfm_pkg::CMD_MARK_EMPTY: begin
          if (idx < scfm_pkg::CLASS_COUNT) nonempty_bits[idx] = 1'b0;
        end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_word(map_result_t got);
      map_result_t want;
      bit bad;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
        return;
      end
      want = pending_results.pop_front();
      bad = (got.ceiling !== want.ceiling) || (got.filed !== want.filed) ||
            (got.hit !== want.hit) || (got.hit_cls !== want.hit_cls) ||
            (got.fb_valid !== want.fb_valid) || (got.fb_cls !== want.fb_cls);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: exp ceil %0d ins %0d hit %0d/%0d fb %0d/%0d",
                   $realtime, want.ceiling, want.filed, want.hit, want.hit_cls,
                   want.fb_valid, want.fb_cls);
          $display("                 got ceil %0d ins %0d hit %0d/%0d fb %0d/%0d",
                   got.ceiling, got.filed, got.hit, got.hit_cls, got.fb_valid,
                   got.fb_cls);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  cmd_i;
  logic [31:0] request_size_i;
  logic [5:0]  class_index_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [5:0]  ceiling_class_o;
  logic [5:0]  insert_class_o;
  logic        hit_o;
  logic [5:0]  hit_class_o;
  logic        fallback_valid_o;
  logic [5:0]  fallback_class_o;

  class_map_checker sb;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      stall_cycles;
  bit               hold_rx_req;

  size_class_free_map_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .request_size_i   (request_size_i),
    .class_index_i    (class_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .ceiling_class_o  (ceiling_class_o),
    .insert_class_o   (insert_class_o),
    .hit_o            (hit_o),
    .hit_class_o      (hit_class_o),
    .fallback_valid_o (fallback_valid_o),
    .fallback_class_o (fallback_class_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_word(scfm_pkg::cmd_e'(cmd_i), request_size_i, class_index_i);
      if (out_valid_o && out_ready_i)
        sb.check_word(map_result_t'{ceiling_class_o, insert_class_o, hit_o, hit_class_o,
                                    fallback_valid_o, fallback_class_o});
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : receiver
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rx_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rx_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic offer_word(input scfm_pkg::cmd_e c, input logic [31:0] sz,
                            input logic [5:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= c;
    request_size_i <= sz;
    class_index_i  <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_size();
    int unsigned k;
    case ($urandom_range(5))
      0: return $urandom_range(40);
      1: return $urandom_range(1100);
      2: begin
        k = $urandom_range(10, 21);
        return (32'd1 << k) + $urandom_range(2) - 1;
      end
      3: return 32 * $urandom_range(1, 32) + $urandom_range(2) - 1;
      4: return $urandom_range(32'h0030_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic scfm_pkg::cmd_e pick_cmd();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return scfm_pkg::CMD_FIND;
    if (r < 70) return scfm_pkg::CMD_INSERT;
    if (r < 94) return scfm_pkg::CMD_MARK_EMPTY;
    return scfm_pkg::CMD_NOP;
  endfunction

  task automatic run_phase(input int n, input int unsigned tx_idle, input int unsigned rx_idle,
                           input bit with_hold);
    logic [5:0] idx;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 3) hold_rx_req = 1'b1;
      idx = ($urandom_range(99) < 85) ? 6'($urandom_range(47)) : 6'($urandom_range(48, 63));
      offer_word(pick_cmd(), pick_size(), idx);
    end
    drain_results();
  endtask

  initial begin : stimulus
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_ready_i    = 1'b0;
    cmd_i          = scfm_pkg::CMD_NOP;
    request_size_i = '0;
    class_index_i  = '0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    stall_cycles   = 0;
    hold_rx_req    = 1'b0;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_word(scfm_pkg::CMD_FIND, 32'd0, 6'd0);
    offer_word(scfm_pkg::CMD_INSERT, 32'd0, 6'd0);
    offer_word(scfm_pkg::CMD_FIND, 32'd7, 6'd0);
    offer_word(scfm_pkg::CMD_INSERT, 32'd8, 6'd0);
    offer_word(scfm_pkg::CMD_INSERT, 32'd24, 6'd0);
    offer_word(scfm_pkg::CMD_INSERT, 32'd25, 6'd0);
    offer_word(scfm_pkg::CMD_INSERT, 32'd32, 6'd0);
    offer_word(scfm_pkg::CMD_INSERT, 32'd33, 6'd0);
    offer_word(scfm_pkg::CMD_INSERT, 32'd1024, 6'd0);
    offer_word(scfm_pkg::CMD_INSERT, 32'd1025, 6'd0);
    offer_word(scfm_pkg::CMD_INSERT, 32'd2048, 6'd0);
    offer_word(scfm_pkg::CMD_INSERT, 32'd2049, 6'd0);
    offer_word(scfm_pkg::CMD_INSERT, scfm_pkg::TOP_SIZE, 6'd0);
    offer_word(scfm_pkg::CMD_INSERT, scfm_pkg::TOP_SIZE + 1, 6'd0);
    offer_word(scfm_pkg::CMD_INSERT, 32'hFFFF_FFFF, 6'd0);
    offer_word(scfm_pkg::CMD_FIND, 32'd9, 6'd0);
    offer_word(scfm_pkg::CMD_FIND, 32'd1023, 6'd0);
    offer_word(scfm_pkg::CMD_FIND, scfm_pkg::TOP_SIZE - 1, 6'd0);
    offer_word(scfm_pkg::CMD_FIND, 32'hFFFF_FFFF, 6'd0);
    offer_word(scfm_pkg::CMD_MARK_EMPTY, 32'd0, 6'(scfm_pkg::CATCH_ALL_CLASS));
    offer_word(scfm_pkg::CMD_FIND, 32'h8000_0000, 6'd0);
    offer_word(scfm_pkg::CMD_MARK_EMPTY, 32'hFFFF_FFFF, 6'd63);
    offer_word(scfm_pkg::CMD_MARK_EMPTY, 32'd0, 6'd47);
    offer_word(scfm_pkg::CMD_NOP, 32'h5555_AAAA, 6'd42);
    offer_word(scfm_pkg::CMD_MARK_EMPTY, 32'd0, 6'd0);
    offer_word(scfm_pkg::CMD_FIND, 32'd31, 6'd0);
    drain_results();

    run_phase(610, 24, 87, 1'b0);
    run_phase(610, 87, 24, 1'b0);
    run_phase(610, 0, 0, 1'b1);

    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
